### design/ipdfx_pkg.sv
// ----------------------------------------------------------------------------
// ipdfx_pkg
// shared constants for the +IPD frame extractor: header characters and widths
// ----------------------------------------------------------------------------
`default_nettype none

package ipdfx_pkg;

	// header and length characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CH_I     = 8'h49;  // 'I'
	localparam logic [7:0] CH_P     = 8'h50;  // 'P'
	localparam logic [7:0] CH_D     = 8'h44;  // 'D'
	localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
	localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

	// width of the frame length and the payload byte counter
	localparam int LEN_W = 30;

	// default limit on length characters (digits plus colon)
	localparam int MAX_LENGTH_CHARS_DEF = 10;

	// reset value of the payload limit register
	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd255;

endpackage : ipdfx_pkg

`default_nettype wire

### design/ipd_frame_extractor.sv
// ----------------------------------------------------------------------------
// ipd_frame_extractor
// pulls the payload of "+IPD,<len>:<payload>" records out of a modem stream
// ----------------------------------------------------------------------------
// usage
//   s_axis: one received modem byte per transaction; bytes ahead of a header
//   are dropped. a decimal length of up to MAX_LENGTH_CHARS-1 digits, closed
//   by ':', follows the header, then exactly that many payload bytes.
//   m_axis: one payload byte per transaction; tlast marks the final byte that
//   is emitted for a frame, tuser marks that byte when the frame was longer
//   than max_payload_bytes (the surplus is consumed but never sent).
//   cfg_wr_en / cfg_wr_data: writes max_payload_bytes (zero acts as one);
//   write only while the block is idle.
// throughput
//   one byte per cycle while m_axis_tready is high; a payload byte is on
//   m_axis in the cycle after its input transaction. the rate is set by the
//   single output register, which loads a new byte in the cycle it drains.
// reset
//   arst_n clears the parser to the header hunt, empties the output register
//   and sets the payload limit to 255.
// stalls
//   while a result waits and m_axis_tready is low, s_axis_tready drops;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_frame_extractor
	import ipdfx_pkg::*;
#(
	parameter int MAX_LENGTH_CHARS = MAX_LENGTH_CHARS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,     // max_payload_bytes
	// received byte stream
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,    // [7:0] rx_byte
	// payload stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,    // [7:0] payload_byte
	output logic            m_axis_tlast,    // last
	output logic            m_axis_tuser     // [0] truncated
);

	// enough bits to count length digits up to MAX_LENGTH_CHARS-1
	localparam int DCNT_W = $clog2(MAX_LENGTH_CHARS);
	localparam logic [DCNT_W-1:0] DIGIT_LIMIT = DCNT_W'(MAX_LENGTH_CHARS - 1);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_I,
		PH_P,
		PH_D,
		PH_COMMA,
		PH_LEN,
		PH_DATA
	} phase_t;

	// parser state
	phase_t             phase_q, phase_d;
	logic [DCNT_W-1:0]  digit_cnt_q, digit_cnt_d;
	logic [LEN_W-1:0]   frame_len_q, frame_len_d;
	logic [LEN_W-1:0]   seen_q, seen_d;
	logic [7:0]         max_payload_q;

	// output register
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic               out_trunc_q;

	// per-byte decode
	logic               in_fire;
	logic               emit;
	logic               emit_last;
	logic               emit_trunc;
	logic [7:0]         maxb;
	logic [LEN_W-1:0]   maxb_ext;
	logic [LEN_W-1:0]   seen_inc;
	logic               is_digit;
	logic [LEN_W-1:0]   len_times10;
	phase_t             hunt_phase;

	// output slot frees in the same cycle it is drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_trunc_q;

	// a zero limit acts as one
	assign maxb     = (max_payload_q == 8'd0) ? 8'd1 : max_payload_q;
	assign maxb_ext = LEN_W'(maxb);
	assign seen_inc = seen_q + LEN_W'(1);

	assign is_digit    = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
	// times ten as two shifts and an add
	assign len_times10 = (frame_len_q << 3) + (frame_len_q << 1);

	// a stray '+' can itself start a new header
	assign hunt_phase = (s_axis_tdata == CH_PLUS) ? PH_I : PH_HUNT;

	// payload byte emission, only meaningful in the payload phase
	always_comb begin
		emit       = (phase_q == PH_DATA) && (seen_q < maxb_ext);
		emit_last  = (seen_inc == frame_len_q) || (seen_inc == maxb_ext);
		emit_trunc = emit_last && (frame_len_q > maxb_ext);
	end

	// next parser state for an accepted byte
	always_comb begin
		phase_d     = phase_q;
		digit_cnt_d = digit_cnt_q;
		frame_len_d = frame_len_q;
		seen_d      = seen_q;
		unique case (phase_q)
			PH_HUNT: begin
				phase_d = hunt_phase;
			end
			PH_I: begin
				phase_d = (s_axis_tdata == CH_I) ? PH_P : hunt_phase;
			end
			PH_P: begin
				phase_d = (s_axis_tdata == CH_P) ? PH_D : hunt_phase;
			end
			PH_D: begin
				phase_d = (s_axis_tdata == CH_D) ? PH_COMMA : hunt_phase;
			end
			PH_COMMA: begin
				if (s_axis_tdata == CH_COMMA) begin
					phase_d     = PH_LEN;
					digit_cnt_d = '0;
					frame_len_d = '0;
				end else begin
					phase_d = hunt_phase;
				end
			end
			PH_LEN: begin
				if (s_axis_tdata == CH_COLON) begin
					// empty or zero length drops the frame
					if (digit_cnt_q == '0 || frame_len_q == '0) begin
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_DATA;
						seen_d  = '0;
					end
				end else if (is_digit) begin
					// no room left for the colon: drop the frame
					if (digit_cnt_q >= DIGIT_LIMIT) begin
						phase_d = PH_HUNT;
					end else begin
						frame_len_d = len_times10 + LEN_W'(s_axis_tdata[3:0]);
						digit_cnt_d = digit_cnt_q + DCNT_W'(1);
					end
				end else begin
					phase_d = hunt_phase;
				end
			end
			PH_DATA: begin
				seen_d = seen_inc;
				if (seen_inc >= frame_len_q) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = hunt_phase;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			digit_cnt_q   <= '0;
			frame_len_q   <= '0;
			seen_q        <= '0;
			max_payload_q <= MAX_PAYLOAD_RST;
			out_valid_q   <= 1'b0;
			out_byte_q    <= '0;
			out_last_q    <= 1'b0;
			out_trunc_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_payload_q <= cfg_wr_data;
			end
			if (in_fire) begin
				phase_q     <= phase_d;
				digit_cnt_q <= digit_cnt_d;
				frame_len_q <= frame_len_d;
				seen_q      <= seen_d;
			end
			if (in_fire && emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= s_axis_tdata;
				out_last_q  <= emit_last;
				out_trunc_q <= emit_trunc;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// truncation is only ever flagged on the final byte
	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("truncated flag without last");

	// a new result only comes from a byte taken in the payload phase
	a_emit_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_fire && phase_q == PH_DATA))
		else $error("result without a payload byte");

	// digit counter never passes the length character limit
	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_cnt_q <= DIGIT_LIMIT)
		else $error("digit counter out of range");

	// inside a frame the consumed count stays below the frame length
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> seen_q < frame_len_q)
		else $error("payload counter past frame length");
`endif

endmodule : ipd_frame_extractor

`default_nettype wire
